[rtl/lrf_pkg.sv]
// Shared types and constants for the rectangle-fill command stream.
`timescale 1ns / 1ps

package lrf_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned BYTE_W  = 8;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 16'd320;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 16'd240;

    // Display controller commands
    localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2C;

    // Input command codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_PULL  = 1'b1;

    localparam int unsigned HDR_BYTES = 11;
    localparam int unsigned IDX_W     = $clog2(HDR_BYTES);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_OFFSCREEN = 2'd1,
        ST_BUSY      = 2'd2,
        ST_IDLE      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        JOB_STATUS = 2'd0,
        JOB_HEADER = 2'd1,
        JOB_PIXEL  = 2'd2
    } job_kind_t;

    // One classified item. Header: a=x, b=x end, c=y, d=y end, flag=empty.
    // Pixel: a=color, flag=fill done. Status: only status is used.
    typedef struct packed {
        job_kind_t          kind;
        status_t            status;
        logic [COORD_W-1:0] word_a;
        logic [COORD_W-1:0] word_b;
        logic [COORD_W-1:0] word_c;
        logic [COORD_W-1:0] word_d;
        logic               flag;
    } job_t;

endpackage

[rtl/lrf_front.sv]
// Front end: accepts items, clips rectangles, tracks the fill and queues jobs.
`timescale 1ns / 1ps

module lrf_front
    import lrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [79:0]            s_tdata,
    input  logic                   s_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data,
    input  logic                   queue_full,
    output logic                   push,
    output job_t                   push_job
);

    logic [COORD_W-1:0] screen_w_reg, screen_h_reg;
    logic               fill_active_reg, fill_active_next;
    logic [COORD_W-1:0] color_reg, color_next;
    logic [COORD_W-1:0] clip_w_reg, clip_w_next;
    logic [COORD_W-1:0] pix_left_reg, pix_left_next;
    logic [COORD_W-1:0] rows_left_reg, rows_left_next;

    logic [COORD_W-1:0] x, y, w, h, color;
    logic               clip_x, clip_y, offscreen, empty, done;
    logic [COORD_W-1:0] w_eff, h_eff, x_end, y_end;

    assign x     = s_tdata[15:0];
    assign y     = s_tdata[31:16];
    assign w     = s_tdata[47:32];
    assign h     = s_tdata[63:48];
    assign color = s_tdata[79:64];

    assign s_tready  = !queue_full;
    assign push      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Clip when x + w - 1 reaches past the screen edge (no wrap).
    assign clip_x = ({1'b0, x} + {1'b0, w}) >= ({1'b0, screen_w_reg} + 17'd1);
    assign clip_y = ({1'b0, y} + {1'b0, h}) >= ({1'b0, screen_h_reg} + 17'd1);
    assign w_eff  = clip_x ? screen_w_reg - x : w;
    assign h_eff  = clip_y ? screen_h_reg - y : h;
    assign x_end  = clip_x ? screen_w_reg - 16'd1 : x + w - 16'd1;
    assign y_end  = clip_y ? screen_h_reg - 16'd1 : y + h - 16'd1;
    // A clipped side is never zero since the corner is on screen.
    assign empty     = (!clip_x && (w == '0)) || (!clip_y && (h == '0));
    assign offscreen = (x >= screen_w_reg) || (y >= screen_h_reg);
    assign done      = (pix_left_reg == 16'd1) && (rows_left_reg == 16'd1);

    always_comb
    begin
        fill_active_next = fill_active_reg;
        color_next       = color_reg;
        clip_w_next      = clip_w_reg;
        pix_left_next    = pix_left_reg;
        rows_left_next   = rows_left_reg;
        push_job         = '0;
        push_job.kind    = JOB_STATUS;
        push_job.status  = ST_VALID;
        if (s_tuser == OP_START) begin
            if (fill_active_reg) begin
                push_job.status = ST_BUSY;
            end else if (offscreen) begin
                push_job.status = ST_OFFSCREEN;
            end else begin
                push_job.kind   = JOB_HEADER;
                push_job.word_a = x;
                push_job.word_b = x_end;
                push_job.word_c = y;
                push_job.word_d = y_end;
                push_job.flag   = empty;
                if (push) begin
                    color_next       = color;
                    clip_w_next      = w_eff;
                    pix_left_next    = w_eff;
                    rows_left_next   = h_eff;
                    fill_active_next = !empty;
                end
            end
        end else begin
            if (!fill_active_reg) begin
                push_job.status = ST_IDLE;
            end else begin
                push_job.kind   = JOB_PIXEL;
                push_job.word_a = color_reg;
                push_job.flag   = done;
                if (push) begin
                    if (pix_left_reg == 16'd1) begin
                        pix_left_next  = clip_w_reg;
                        rows_left_next = rows_left_reg - 16'd1;
                        if (rows_left_reg == 16'd1) begin
                            fill_active_next = 1'b0;
                        end
                    end else begin
                        pix_left_next = pix_left_reg - 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            screen_w_reg    <= SCREEN_WIDTH_RST;
            screen_h_reg    <= SCREEN_HEIGHT_RST;
            fill_active_reg <= 1'b0;
            color_reg       <= '0;
            clip_w_reg      <= '0;
            pix_left_reg    <= '0;
            rows_left_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  screen_w_reg <= cfg_data;
                    REG_SCREEN_HEIGHT: screen_h_reg <= cfg_data;
                    default: ;
                endcase
            end
            fill_active_reg <= fill_active_next;
            color_reg       <= color_next;
            clip_w_reg      <= clip_w_next;
            pix_left_reg    <= pix_left_next;
            rows_left_reg   <= rows_left_next;
        end
    end

    // A fill ends only on an accepted pull.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(fill_active_reg) |-> $past(push && (s_tuser == OP_PULL)))
        else $error("fill ended without a pull");

endmodule

[rtl/lrf_queue.sv]
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module lrf_queue
    import lrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    job_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule

[rtl/lrf_back.sv]
// Back end: walks each queued job; one byte per cycle unless stalled.
`timescale 1ns / 1ps

module lrf_back
    import lrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              not_empty,
    input  job_t              head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic [3:0]        m_tuser,
    output logic              m_tlast
);

    logic [IDX_W-1:0]  idx_reg, last_idx;
    logic              advance;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              is_data_reg, is_data_next;
    status_t           status_reg, status_next;
    logic              frame_end_reg, frame_end_next;
    logic              last_reg;

    always_comb
    begin
        unique case (head.kind)
            JOB_HEADER: last_idx = IDX_W'(HDR_BYTES - 1);
            JOB_PIXEL:  last_idx = IDX_W'(1);
            default:    last_idx = '0;
        endcase
    end

    always_comb
    begin
        byte_next      = '0;
        is_data_next   = 1'b0;
        status_next    = head.status;
        frame_end_next = 1'b0;
        unique case (head.kind)
            JOB_HEADER:
            begin
                status_next  = ST_VALID;
                is_data_next = 1'b1;
                unique case (idx_reg)
                    4'd0:
                    begin
                        byte_next    = CMD_COLUMN;
                        is_data_next = 1'b0;
                    end
                    4'd1: byte_next = head.word_a[15:8];
                    4'd2: byte_next = head.word_a[7:0];
                    4'd3: byte_next = head.word_b[15:8];
                    4'd4: byte_next = head.word_b[7:0];
                    4'd5:
                    begin
                        byte_next    = CMD_PAGE;
                        is_data_next = 1'b0;
                    end
                    4'd6: byte_next = head.word_c[15:8];
                    4'd7: byte_next = head.word_c[7:0];
                    4'd8: byte_next = head.word_d[15:8];
                    4'd9: byte_next = head.word_d[7:0];
                    default:
                    begin
                        byte_next      = CMD_WRITE;
                        is_data_next   = 1'b0;
                        frame_end_next = head.flag;
                    end
                endcase
            end
            JOB_PIXEL:
            begin
                status_next  = ST_VALID;
                is_data_next = 1'b1;
                if (idx_reg == '0) begin
                    byte_next = head.word_a[15:8];
                end else begin
                    byte_next      = head.word_a[7:0];
                    frame_end_next = head.flag;
                end
            end
            default: ;
        endcase
    end

    assign advance = !valid_reg || m_tready;
    assign pop     = advance && not_empty && (idx_reg == last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= not_empty;
            if (not_empty) begin
                idx_reg <= (idx_reg == last_idx) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && not_empty) begin
            byte_reg      <= byte_next;
            is_data_reg   <= is_data_next;
            status_reg    <= status_next;
            frame_end_reg <= frame_end_next;
            last_reg      <= (idx_reg == last_idx);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {frame_end_reg, status_reg, is_data_reg};
    assign m_tlast  = last_reg;

    // The fill's final byte always closes its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && frame_end_reg) |-> last_reg)
        else $error("frame end without last");
    // Byte index never runs past the current job.
    assert property (@(posedge clk) disable iff (!rst_n)
        not_empty |-> (idx_reg <= last_idx))
        else $error("byte index beyond job length");

endmodule

[rtl/lcd_rect_fill_command_stream.sv]
// Top level of the rectangle-fill command stream.
`timescale 1ns / 1ps

// Turns rectangle-fill requests into display controller bytes.
// Input channel s_*: s_tuser = 0 starts a fill (rectangle and color in
// s_tdata), s_tuser = 1 pulls the next pixel. Output channel m_*: one
// byte per transfer, marked as command or data in m_tuser; m_tlast closes
// the bytes caused by one input item. A start emits eleven header bytes,
// a pull two pixel bytes, and a rejected or ignored item one status byte.
// Config channel cfg_*: index 0 screen width, index 1 screen height, always
// ready; write only while the block is idle.
// With the queue empty, the first byte of an item goes into the job queue
// and then into the output byte register, where it is valid.
// Throughput: one output byte per cycle from the byte sequencer while the
// receiver is ready. A four-entry job queue between the input
// classifier and the sequencer lets input transfers continue while the
// sequencer works or the receiver stalls; s_tready drops when it fills.
// Reset: screen 320 x 240, no fill active, queue and output empty.
// A stalled receiver holds the current byte steady until taken.

module lcd_rect_fill_command_stream
    import lrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [79:0]            s_tdata,   // left_x, top_y, rect_width, rect_height, fill_color
    input  logic                   s_tuser,   // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // out_byte
    output logic [3:0]             m_tuser,   // is_data, status[1:0], frame_end
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data
);

    logic push, pop, queue_full, not_empty;
    job_t push_job, head;

    lrf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    lrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (not_empty),
        .head      (head)
    );

    lrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the rectangle-fill command stream.
`timescale 1ns / 1ps

module testbench;
    import lrf_pkg::*;

    localparam int unsigned CLK_HALF        = 5;
    localparam int unsigned RESET_CYCLES    = 8;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned ITEMS_PER_PHASE = 60;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned NUM_DIRECTED    = 22;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_data;
        status_t           status;
        logic              frame_end;
        logic              last;
    } byte_result_t;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] color;
        logic               fixed;
        status_t            fixed_status;
    } stim_row_t;

    // Rows marked fixed carry a single status byte that needs no predictor.
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b1, ST_IDLE},
        '{OP_START, 16'd320,   16'd0,     16'd1,     16'd1,     16'h00FF,  1'b1, ST_OFFSCREEN},
        '{OP_START, 16'd0,     16'd240,   16'd1,     16'd1,     16'hFF00,  1'b1, ST_OFFSCREEN},
        '{OP_START, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, ST_OFFSCREEN},
        '{OP_START, 16'd0,     16'd0,     16'd0,     16'd5,     16'h0000,  1'b0, ST_VALID},
        '{OP_START, 16'd0,     16'd0,     16'd320,   16'd0,     16'hC3C3,  1'b0, ST_VALID},
        '{OP_START, 16'd0,     16'd0,     16'd2,     16'd2,     16'hFFFF,  1'b0, ST_VALID},
        '{OP_START, 16'd10,    16'd10,    16'd3,     16'd3,     16'h0000,  1'b1, ST_BUSY},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b1, ST_IDLE},
        '{OP_START, 16'd319,   16'd239,   16'hFFFF,  16'hFFFF,  16'h8001,  1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_START, 16'd318,   16'd0,     16'd5,     16'd1,     16'h1234,  1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_START, 16'h0100,  16'h00EF,  16'd3,     16'd1,     16'h5AA5,  1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID},
        '{OP_PULL,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0, ST_VALID}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [79:0]            s_tdata;   // left_x, top_y, rect_width, rect_height, fill_color
    logic                   s_tuser;   // command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [BYTE_W-1:0]      m_tdata;   // out_byte
    logic [3:0]             m_tuser;   // is_data, status[1:0], frame_end
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COORD_W-1:0]     cfg_data;

    // Predicted state of the block
    logic [COORD_W-1:0] screen_w;
    logic [COORD_W-1:0] screen_h;
    logic               fill_on;
    logic [COORD_W-1:0] fill_color_q;
    logic [COORD_W-1:0] fill_width_q;
    logic [COORD_W-1:0] row_pixels_left;
    logic [COORD_W-1:0] rows_to_go;

    byte_result_t expected_bytes [$];

    int unsigned tx_idle_pct = 25;
    int unsigned rx_idle_pct = 74;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned bytes_checked = 0;
    int unsigned items_sent = 0;
    int unsigned fills_done = 0;

    lcd_rect_fill_command_stream u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
                     expected_bytes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_output
        byte_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected byte %02h user %01h last %0b", m_tdata, m_tuser, m_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (m_tdata !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.is_data)
                begin
                    $error("is_data: expected %0b, got %0b", want.is_data, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[2:1] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
                    fail_count++;
                end
                if (m_tuser[3] !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, m_tuser[3]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic d,
                                      input status_t st, input logic fe, input logic lst);
        byte_result_t r;
        r.out_byte  = b;
        r.is_data   = d;
        r.status    = st;
        r.frame_end = fe;
        r.last      = lst;
        expected_bytes.push_back(r);
    endfunction

    // Work out the byte stream caused by one accepted item and advance the state.
    function automatic void predict_fill_bytes(input logic cmd, input logic [15:0] x,
                                               input logic [15:0] y, input logic [15:0] w,
                                               input logic [15:0] h, input logic [15:0] color);
        logic [COORD_W-1:0] cw;
        logic [COORD_W-1:0] ch;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic               empty;
        logic               done;
        cw = w;
        ch = h;
        if (cmd == OP_START)
        begin
            if (fill_on)
                push_byte('0, 1'b0, ST_BUSY, 1'b0, 1'b1);
            else if (x >= screen_w || y >= screen_h)
                push_byte('0, 1'b0, ST_OFFSCREEN, 1'b0, 1'b1);
            else
            begin
                // clip where the far edge runs past the screen, without wrap
                if ({1'b0, x} + {1'b0, w} >= {1'b0, screen_w} + 17'd1)
                    cw = screen_w - x;
                if ({1'b0, y} + {1'b0, h} >= {1'b0, screen_h} + 17'd1)
                    ch = screen_h - y;
                x_end = x + cw - 16'd1;
                y_end = y + ch - 16'd1;
                empty = (cw == '0) || (ch == '0);
                push_byte(CMD_COLUMN, 1'b0, ST_VALID, 1'b0, 1'b0);
                push_byte(x[15:8], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(x[7:0], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(x_end[15:8], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(x_end[7:0], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(CMD_PAGE, 1'b0, ST_VALID, 1'b0, 1'b0);
                push_byte(y[15:8], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(y[7:0], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(y_end[15:8], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(y_end[7:0], 1'b1, ST_VALID, 1'b0, 1'b0);
                push_byte(CMD_WRITE, 1'b0, ST_VALID, empty, 1'b1);
                if (empty)
                    fills_done++;
                fill_color_q    = color;
                fill_width_q    = cw;
                row_pixels_left = cw;
                rows_to_go      = ch;
                fill_on         = !empty;
            end
        end
        else if (!fill_on)
            push_byte('0, 1'b0, ST_IDLE, 1'b0, 1'b1);
        else
        begin
            done = 1'b0;
            row_pixels_left = row_pixels_left - 16'd1;
            if (row_pixels_left == '0)
            begin
                rows_to_go      = rows_to_go - 16'd1;
                row_pixels_left = fill_width_q;
                if (rows_to_go == '0)
                begin
                    done    = 1'b1;
                    fill_on = 1'b0;
                    fills_done++;
                end
            end
            push_byte(fill_color_q[15:8], 1'b1, ST_VALID, 1'b0, 1'b0);
            push_byte(fill_color_q[7:0], 1'b1, ST_VALID, done, 1'b1);
        end
    endfunction

    task automatic send_item(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] color);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {color, h, w, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Hold off until every expected byte has arrived, then let the pipeline settle.
    task automatic drain_outputs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_screen(input logic [15:0] w, input logic [15:0] h);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        screen_w = w;
        screen_h = h;
    endtask

    // Pick a coordinate on screen, near its far edge, or past it.
    function automatic logic [15:0] pick_coord(input logic [15:0] limit, input int unsigned mode);
        int unsigned lim;
        int unsigned back;
        lim = 32'(limit);
        if (mode == 2 || lim == 0)
            return (lim >= 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(lim, 16'hFFFF));
        if (mode == 1)
        begin
            back = $urandom_range(1, 4);
            return (back > lim) ? 16'd0 : 16'(lim - back);
        end
        return 16'($urandom_range(0, lim - 1));
    endfunction

    task automatic send_random_start();
        int unsigned r;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        r = $urandom_range(0, 99);
        w = 16'($urandom_range(0, 6));
        h = 16'($urandom_range(0, 6));
        if (r < 60)
        begin
            x = pick_coord(screen_w, 0);
            y = pick_coord(screen_h, 0);
        end
        else if (r < 78)
        begin
            // land near the far edge so the clip can engage
            x = pick_coord(screen_w, 1);
            y = pick_coord(screen_h, 1);
            if ($urandom_range(0, 1))
                w = 16'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 1))
                h = 16'($urandom_range(0, 16'hFFFF));
        end
        else if (r < 90)
        begin
            x = pick_coord(screen_w, $urandom_range(0, 1) ? 2 : 0);
            y = pick_coord(screen_h, 2);
            if ($urandom_range(0, 1))
                {x, y} = {y, x};
        end
        else
        begin
            x = 16'($urandom_range(0, 16'hFFFF));
            y = 16'($urandom_range(0, 16'hFFFF));
            w = 16'($urandom_range(0, 16'hFFFF));
            h = 16'($urandom_range(0, 16'hFFFF));
        end
        send_item(OP_START, x, y, w, h, 16'($urandom_range(0, 16'hFFFF)));
        predict_fill_bytes(OP_START, x, y, w, h, s_tdata[79:64]);
    endtask

    task automatic run_random_phase();
        logic [15:0] junk;
        for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++)
        begin
            // mostly finish the fill in progress; start on idle, with some noise
            if (fill_on ? ($urandom_range(0, 99) < 8) : ($urandom_range(0, 99) < 85))
                send_random_start();
            else
            begin
                junk = 16'($urandom_range(0, 16'hFFFF));
                send_item(OP_PULL, junk, ~junk, junk, ~junk, junk);
                predict_fill_bytes(OP_PULL, junk, ~junk, junk, ~junk, junk);
            end
        end
    endtask

    initial
    begin : stimulus
        stim_row_t row;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tuser         = OP_START;
        s_tdata         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_SCREEN_WIDTH;
        cfg_data        = '0;
        screen_w        = SCREEN_WIDTH_RST;
        screen_h        = SCREEN_HEIGHT_RST;
        fill_on         = 1'b0;
        fill_color_q    = '0;
        fill_width_q    = '0;
        row_pixels_left = '0;
        rows_to_go      = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = DIRECTED[i];
            send_item(row.cmd, row.x, row.y, row.w, row.h, row.color);
            if (row.fixed)
                push_byte('0, 1'b0, row.fixed_status, 1'b0, 1'b1);
            else
                predict_fill_bytes(row.cmd, row.x, row.y, row.w, row.h, row.color);
        end
        drain_outputs();

        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            tx_idle_pct = (p < 2) ? 25 : (p < 4) ? 74 : 0;
            rx_idle_pct = (p < 2) ? 74 : (p < 4) ? 25 : 0;
            case (p)
                1: write_screen(16'hFFFF, 16'hFFFF);
                2: write_screen(16'd1, 16'd1);
                3: write_screen(16'd0, 16'd0);
                4: write_screen(16'($urandom_range(2, 400)), 16'($urandom_range(2, 300)));
                5: write_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
                default: ;
            endcase
            run_random_phase();
            drain_outputs();
        end

        $display("covered %0d items over %0d screen settings, %0d bytes checked",
                 items_sent, NUM_PHASES, bytes_checked);
        $display("fills completed %0d, mismatches %0d", fills_done, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
